@@ hw/rtl/bpt_pkg.sv @@
// Shared types and constants of the block power trigger.
`default_nettype none

package bpt_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 32;
    localparam int SUM_W    = 43;
    localparam int THR_W    = 31;
    localparam int TICK_W   = 16;
    localparam int CAP_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_POST_TICKS = 2'd1,
        CFG_CAP_LIMIT  = 2'd2
    } t_cfg_idx;

    // Item kinds carried in tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // Item handed from the energy stage to the detector
    typedef struct packed {
        logic                func;
        logic                last;
        logic [ENERGY_W-1:0] energy;
    } t_sq_item;

    // Result item from the detector
    typedef struct packed {
        logic             block_end;
        logic [SUM_W-1:0] block_power;
        logic             triggered;
        logic             capture_active;
        logic             capture_done;
        logic [CAP_W-1:0] capture_total;
        logic             finished;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/block_power_trigger.sv @@
// Top level of the block power trigger: stream ports, configuration port, result packing.
//
//  channel   dir  handshake                     payload
//  s         in   i_s_tvalid / o_s_tready       tdata {q,i}, tlast last_of_block, tuser func
//  m         out  o_m_tvalid / i_m_tready       tdata {capture_total,block_power}, tlast, tuser
//  cfg       in   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken and no threshold reload holds the input;
// each item passes the input, energy and result registers in turn before its result is valid.
// A threshold write holds o_s_tready low while the threshold times
// the current block count is reloaded through one multiplier.
// Reset (i_rst_n low, synchronous) clears the detector state, configuration and valid flags;
// the payload registers are not reset; no clearing pass.
// A stalled result register fills the stages behind it, then o_s_tready drops.
`default_nettype none

module block_power_trigger
    import bpt_pkg::*;
#(
    parameter int BLOCK_SAMPLES = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [31:0]          i_s_tdata,   // [15:0] i_sample, [31:16] q_sample
    input  wire logic                 i_s_tlast,   // last_of_block
    input  wire logic                 i_s_tuser,   // [0] func
    // Result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [63:0]               o_m_tdata,   // [42:0] block_power, [58:43] capture_total
    output logic                      o_m_tlast,   // block_end
    output logic [3:0]                o_m_tuser,   // [0] triggered, [1] capture_active,
                                                   // [2] capture_done, [3] finished
    // Configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [THR_W-1:0]     i_cfg_data
);

    logic     w_hold;
    logic     w_item_valid;
    logic     w_item_ready;
    t_sq_item w_item;
    t_result  w_res;

    assign o_cfg_ready = 1'b1;

    // Input register and energy stage
    bpt_energy u_energy (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_func       (i_s_tuser),
        .i_last       (i_s_tlast),
        .i_i_sample   (i_s_tdata[SAMPLE_W-1:0]),
        .i_q_sample   (i_s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .i_hold       (w_hold),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_ready (w_item_ready)
    );

    // Detector and result register
    bpt_detect #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_detect (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_hold       (w_hold),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_ready (w_item_ready),
        .o_res_valid  (o_m_tvalid),
        .o_res        (w_res),
        .i_res_ready  (i_m_tready)
    );

    // Pack the result item
    assign o_m_tdata = {5'b0, w_res.capture_total, w_res.block_power};
    assign o_m_tlast = w_res.block_end;
    assign o_m_tuser = {w_res.finished, w_res.capture_done,
                        w_res.capture_active, w_res.triggered};

endmodule

`default_nettype wire

@@ hw/rtl/bpt_energy.sv @@
// Input register and sample energy stage (I squared plus Q squared).
`default_nettype none

module bpt_energy
    import bpt_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_func,
    input  wire logic                       i_last,
    input  wire logic signed [SAMPLE_W-1:0] i_i_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_q_sample,
    input  wire logic                       i_hold,
    output logic                            o_item_valid,
    output t_sq_item                        o_item,
    input  wire logic                       i_item_ready
);

    logic                       r_v1;
    logic                       r_func1;
    logic                       r_last1;
    logic signed [SAMPLE_W-1:0] r_i1;
    logic signed [SAMPLE_W-1:0] r_q1;
    logic                       r_v2;
    t_sq_item                   r_item2;
    t_sq_item                   n_item2;
    logic signed [2*SAMPLE_W-1:0] w_sq_i;
    logic signed [2*SAMPLE_W-1:0] w_sq_q;
    logic                       w_adv2;
    logic                       w_adv1;
    logic                       w_take;

    // Advance each stage when the one after it has room
    assign w_adv2  = !r_v2 || i_item_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1 && !i_hold;
    assign w_take  = i_valid && o_ready;

    // Squares never exceed 2^30, so the low 31 bits hold them
    assign w_sq_i = r_i1 * r_i1;
    assign w_sq_q = r_q1 * r_q1;

    always_comb begin
        n_item2.func   = r_func1;
        n_item2.last   = r_last1;
        n_item2.energy = {1'b0, w_sq_i[ENERGY_W-2:0]} + {1'b0, w_sq_q[ENERGY_W-2:0]};
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= w_take;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_func1 <= i_func;
            r_last1 <= i_last;
            r_i1    <= i_i_sample;
            r_q1    <= i_q_sample;
        end
        if (w_adv2 && r_v1) begin
            r_item2 <= n_item2;
        end
    end

    assign o_item_valid = r_v2;
    assign o_item       = r_item2;

endmodule

`default_nettype wire

@@ hw/rtl/bpt_detect.sv @@
// Block energy accumulator, threshold compare, capture window and result register.
`default_nettype none

module bpt_detect
    import bpt_pkg::*;
#(
    parameter int BLOCK_SAMPLES = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [THR_W-1:0]     i_cfg_data,
    output logic                      o_hold,
    input  wire logic                 i_item_valid,
    input  wire t_sq_item             i_item,
    output logic                      o_item_ready,
    output logic                      o_res_valid,
    output t_result                   o_res,
    input  wire logic                 i_res_ready
);

    localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);
    localparam int ACC_W = THR_W + CNT_W;
    localparam int CMP_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BLOCK_SAMPLES);

    // Configuration
    logic [THR_W-1:0]  r_threshold;
    logic [TICK_W-1:0] r_post_ticks;
    logic [CAP_W-1:0]  r_cap_limit;
    logic              r_recalc;

    // Detector state
    logic [SUM_W-1:0]  r_psum,   n_psum;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic [ACC_W-1:0]  r_thracc, n_thracc;
    logic              r_capt,   n_capt;
    logic [TICK_W-1:0] r_ticks,  n_ticks;
    logic [CAP_W-1:0]  r_caps,   n_caps;
    logic              r_done,   n_done;

    // Result register
    logic              r_out_valid;
    t_result           r_res, n_res;

    logic              w_consume;
    logic [SUM_W:0]    w_sum_ext;
    logic [SUM_W-1:0]  w_sum_sat;
    logic [CNT_W-1:0]  w_cnt1;
    logic [ACC_W-1:0]  w_thr1;
    logic [TICK_W-1:0] w_tick_dec;
    logic [CAP_W-1:0]  w_caps_inc;
    logic              w_finish;

    assign o_item_ready = (!r_out_valid || i_res_ready) && !r_recalc;
    assign w_consume    = i_item_valid && o_item_ready;
    assign o_hold       = r_recalc;

    // Configuration writes; a threshold write reloads the threshold-times-count product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= '0;
            r_post_ticks <= '0;
            r_cap_limit  <= '0;
            r_recalc     <= 1'b0;
        end else begin
            r_recalc <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: begin
                        r_threshold <= i_cfg_data;
                        r_recalc    <= 1'b1;
                    end
                    CFG_POST_TICKS: r_post_ticks <= i_cfg_data[TICK_W-1:0];
                    CFG_CAP_LIMIT:  r_cap_limit  <= i_cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Running sums for a sample
    assign w_sum_ext  = {1'b0, r_psum} + (SUM_W+1)'(i_item.energy);
    assign w_sum_sat  = w_sum_ext[SUM_W] ? SUM_MAX : w_sum_ext[SUM_W-1:0];
    assign w_cnt1     = r_cnt + CNT_W'(1);
    assign w_thr1     = r_thracc + ACC_W'(r_threshold);
    assign w_tick_dec = (r_ticks != '0) ? (r_ticks - TICK_W'(1)) : r_ticks;
    assign w_caps_inc = (r_caps != CAP_MAX) ? (r_caps + CAP_W'(1)) : r_caps;

    // Next state and result of one item
    always_comb begin
        n_psum   = r_psum;
        n_cnt    = r_cnt;
        n_thracc = r_thracc;
        n_capt   = r_capt;
        n_ticks  = r_ticks;
        n_caps   = r_caps;
        n_done   = r_done;
        w_finish = 1'b0;
        n_res    = '0;

        if (!r_done) begin
            if (i_item.func == FUNC_TICK) begin
                if (r_capt) begin
                    n_ticks = w_tick_dec;
                    if (w_tick_dec == '0) begin
                        w_finish = 1'b1;
                    end
                end
            end else if (!r_capt) begin
                if (i_item.last || (w_cnt1 == CNT_FULL)) begin
                    n_res.block_end   = 1'b1;
                    n_res.block_power = w_sum_sat;
                    if (CMP_W'(w_sum_sat) >= CMP_W'(w_thr1)) begin
                        n_res.triggered = 1'b1;
                        n_capt          = 1'b1;
                        n_ticks         = r_post_ticks;
                        if (r_post_ticks == '0) begin
                            w_finish = 1'b1;
                        end
                    end
                    n_psum   = '0;
                    n_cnt    = '0;
                    n_thracc = '0;
                end else begin
                    n_psum   = w_sum_sat;
                    n_cnt    = w_cnt1;
                    n_thracc = w_thr1;
                end
            end
        end

        // Close the capture window and count it
        if (w_finish) begin
            n_capt  = 1'b0;
            n_ticks = '0;
            n_caps  = w_caps_inc;
            if ((r_cap_limit != '0) && (w_caps_inc >= r_cap_limit)) begin
                n_done = 1'b1;
            end
        end

        n_res.capture_done   = w_finish;
        n_res.capture_active = n_capt;
        n_res.capture_total  = n_caps;
        n_res.finished       = n_done;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum   <= '0;
            r_cnt    <= '0;
            r_thracc <= '0;
            r_capt   <= 1'b0;
            r_ticks  <= '0;
            r_caps   <= '0;
            r_done   <= 1'b0;
        end else if (r_recalc) begin
            r_thracc <= ACC_W'(r_threshold) * ACC_W'(r_cnt);
        end else if (w_consume) begin
            r_psum   <= n_psum;
            r_cnt    <= n_cnt;
            r_thracc <= n_thracc;
            r_capt   <= n_capt;
            r_ticks  <= n_ticks;
            r_caps   <= n_caps;
            r_done   <= n_done;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_trig_closes_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.triggered) |-> r_res.block_end)
        else $error("trigger without a closed block");

    a_power_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.block_end) |-> (r_res.block_power == '0))
        else $error("block power reported outside block end");

    a_done_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.capture_done) |-> !r_res.capture_active)
        else $error("capture closed but still active");

    a_finished_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("finished flag dropped");

    a_no_item_in_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recalc |-> !w_consume)
        else $error("item consumed while threshold product reloads");
`endif

endmodule

`default_nettype wire
